// File: design/cht_pkg.sv
// Shared constants, codes and types of the capture history table.
`default_nettype none

package cht_pkg;

  localparam int NUM_PIECE_TYPES    = 6;
  localparam int NUM_SQUARES        = 64;
  localparam int NUM_CAPTURED_TYPES = 5;
  localparam int TABLE_DEPTH        = NUM_PIECE_TYPES * NUM_SQUARES * NUM_CAPTURED_TYPES;
  localparam int ADDR_W             = $clog2(TABLE_DEPTH);

  localparam int ENTRY_W   = 32;
  localparam int VALUE_W   = 33;
  localparam int DEPTH_W   = 7;
  localparam int BONUS_W   = 16;
  localparam int MULT_W    = 8;
  localparam int DIVISOR_W = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;
  localparam int MB_W      = MULT_W + BONUS_W;
  localparam int PROD_W    = ENTRY_W + BONUS_W;
  localparam int SUM_W     = PROD_W + 2;

  localparam int DIV_STEPS_PER_CYCLE = 2;
  localparam int DIV_CYCLES          = PROD_W / DIV_STEPS_PER_CYCLE;
  localparam int DIV_CNT_W           = $clog2(DIV_CYCLES);

  localparam int QUEEN_BONUS = 64000;

  localparam logic MODE_LOOKUP = 1'b0;
  localparam logic MODE_UPDATE = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BONUS_LIMIT = 2'd0,
    CFG_BONUS_MULT  = 2'd1,
    CFG_DECAY_DIV   = 2'd2
  } cfg_idx_e;

  typedef enum logic [5:0] {
    ST_CLEAR  = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_READ   = 6'b000100,
    ST_DSTART = 6'b001000,
    ST_DWAIT  = 6'b010000,
    ST_FINISH = 6'b100000
  } state_e;

  typedef struct packed {
    logic                 start;
    logic [PROD_W-1:0]    dividend;
    logic [DIVISOR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

// File: design/capture_history_table.sv
// Top level of the capture history table: control, datapath and configuration registers.
// Lookup: table read, then result into the output register; no new item is taken till then.
// Update: table read, then the serial divider of the decay term, then the table
// write-back and the result into the output register; no new item is taken till then.
// Reset clears control and loads the register defaults; a clearing pass then zeroes
// the 1920 table entries, one per cycle, while no item is taken.
`default_nettype none

module capture_history_table (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,

  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [cht_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [cht_pkg::CFG_DAT_W-1:0] cfg_data_i,

  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          mode_i,
  input  wire logic [2:0]                    mover_piece_i,
  input  wire logic [5:0]                    to_square_i,
  input  wire logic [2:0]                    captured_piece_i,
  input  wire logic                          is_en_passant_i,
  input  wire logic                          is_promotion_i,
  input  wire logic                          promotes_to_queen_i,
  input  wire logic                          is_best_i,
  input  wire logic [cht_pkg::DEPTH_W-1:0]   depth_i,
  input  wire logic                          last_in_list_i,

  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic signed [cht_pkg::VALUE_W-1:0] value_o
);

  localparam int AW = cht_pkg::ADDR_W;
  localparam int EW = cht_pkg::ENTRY_W;
  localparam int SW = cht_pkg::SUM_W;
  localparam int VW = cht_pkg::VALUE_W;

  cht_pkg::state_e state_q, state_d;

  logic [cht_pkg::BONUS_W-1:0]   bonus_limit_q;
  logic [cht_pkg::MULT_W-1:0]    bonus_mult_q;
  logic [cht_pkg::DIVISOR_W-1:0] decay_div_q;

  logic [AW-1:0] clr_cnt_q, clr_cnt_d;

  logic                        mode_q, queen_q, best_q, idx_ok_q;
  logic [AW-1:0]               addr_q;
  logic [cht_pkg::BONUS_W-1:0] bonus_q;
  logic signed [EW-1:0]        entry_q;
  logic                        neg_q;
  logic [cht_pkg::PROD_W-1:0]  prod_q;
  logic [cht_pkg::MB_W-1:0]    mb_q;

  logic                   out_valid_q, out_valid_d;
  logic signed [VW-1:0]   value_q, value_d;

  logic                          accept, out_free, finish;
  logic [2:0]                    cap_eff;
  logic                          idx_ok;
  logic [AW-1:0]                 addr_in;
  logic [2*cht_pkg::DEPTH_W-1:0] depth_sq;
  logic [cht_pkg::BONUS_W-1:0]   bonus_in;
  logic signed [EW-1:0]          entry_c;
  logic [EW-1:0]                 mag_c;

  logic signed [SW-1:0] ent_x, mb_x, q_x, term_add, term_dec, sum;
  logic signed [EW-1:0] upd_val;
  logic signed [VW-1:0] lookup_val;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [EW-1:0] ram_wdata;
  logic [EW-1:0] ram_rdata;

  cht_pkg::div_req_t div_req;
  cht_pkg::div_rsp_t div_rsp;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bonus_limit_q <= cht_pkg::BONUS_W'(16384);
      bonus_mult_q  <= cht_pkg::MULT_W'(32);
      decay_div_q   <= cht_pkg::DIVISOR_W'(512);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        cht_pkg::CFG_BONUS_LIMIT: begin
          bonus_limit_q <= cfg_data_i;
        end
        cht_pkg::CFG_BONUS_MULT: begin
          bonus_mult_q <= cfg_data_i[cht_pkg::MULT_W-1:0];
        end
        cht_pkg::CFG_DECAY_DIV: begin
          decay_div_q <= cfg_data_i;
        end
        default: begin
        end
      endcase
    end
  end

  assign in_stall_o = (state_q != cht_pkg::ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign finish     = (state_q == cht_pkg::ST_FINISH) && out_free;

  always_comb begin
    cap_eff  = (is_en_passant_i || is_promotion_i) ? 3'd0 : captured_piece_i;
    idx_ok   = (int'(mover_piece_i) < cht_pkg::NUM_PIECE_TYPES) &&
               (int'(to_square_i) < cht_pkg::NUM_SQUARES) &&
               (int'(cap_eff) < cht_pkg::NUM_CAPTURED_TYPES);
    addr_in  = AW'((int'(mover_piece_i) * cht_pkg::NUM_SQUARES + int'(to_square_i)) *
                   cht_pkg::NUM_CAPTURED_TYPES + int'(cap_eff));
    depth_sq = (2*cht_pkg::DEPTH_W)'(depth_i) * (2*cht_pkg::DEPTH_W)'(depth_i);
    bonus_in = (cht_pkg::BONUS_W'(depth_sq) > bonus_limit_q) ? bonus_limit_q
                                                             : cht_pkg::BONUS_W'(depth_sq);
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q   <= mode_i;
      queen_q  <= promotes_to_queen_i;
      best_q   <= is_best_i;
      idx_ok_q <= idx_ok;
      addr_q   <= addr_in;
      bonus_q  <= bonus_in;
    end
  end

  always_comb begin
    entry_c = idx_ok_q ? $signed(ram_rdata) : '0;
    mag_c   = entry_c[EW-1] ? $unsigned(-entry_c) : $unsigned(entry_c);
  end

  always_ff @(posedge clk_i) begin
    if (state_q == cht_pkg::ST_READ) begin
      entry_q <= entry_c;
      neg_q   <= entry_c[EW-1];
      prod_q  <= cht_pkg::PROD_W'(mag_c) * cht_pkg::PROD_W'(bonus_q);
      mb_q    <= cht_pkg::MB_W'(bonus_mult_q) * cht_pkg::MB_W'(bonus_q);
    end
  end

  assign div_req.start    = (state_q == cht_pkg::ST_DSTART);
  assign div_req.dividend = prod_q;
  assign div_req.divisor  = decay_div_q;

  cht_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    ent_x    = {{(SW-EW){entry_q[EW-1]}}, entry_q};
    mb_x     = SW'(mb_q);
    q_x      = SW'(div_rsp.quotient);
    term_add = best_q ? mb_x : -mb_x;
    term_dec = neg_q ? q_x : -q_x;
    sum      = ent_x + term_add + term_dec;
    if (sum[SW-1:EW-1] != {(SW-EW+1){sum[SW-1]}}) begin
      upd_val = sum[SW-1] ? {1'b1, {(EW-1){1'b0}}} : {1'b0, {(EW-1){1'b1}}};
    end else begin
      upd_val = sum[EW-1:0];
    end
    lookup_val = {{(VW-EW){entry_q[EW-1]}}, entry_q} +
                 (queen_q ? VW'(cht_pkg::QUEEN_BONUS) : '0);
    value_d    = (mode_q == cht_pkg::MODE_UPDATE) ? {{(VW-EW){upd_val[EW-1]}}, upd_val}
                                                  : lookup_val;
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr_q;
    ram_wdata = upd_val;
    if (state_q == cht_pkg::ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_q;
      ram_wdata = '0;
    end else if (finish && (mode_q == cht_pkg::MODE_UPDATE) && idx_ok_q) begin
      ram_we = 1'b1;
    end
  end

  cht_ram #(
    .DEPTH (cht_pkg::TABLE_DEPTH),
    .WIDTH (EW)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (addr_in),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d   = state_q;
    clr_cnt_d = clr_cnt_q;
    case (state_q)
      cht_pkg::ST_CLEAR: begin
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == AW'(cht_pkg::TABLE_DEPTH - 1)) begin
          state_d = cht_pkg::ST_IDLE;
        end
      end
      cht_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = cht_pkg::ST_READ;
        end
      end
      cht_pkg::ST_READ: begin
        state_d = (mode_q == cht_pkg::MODE_UPDATE) ? cht_pkg::ST_DSTART : cht_pkg::ST_FINISH;
      end
      cht_pkg::ST_DSTART: begin
        state_d = cht_pkg::ST_DWAIT;
      end
      cht_pkg::ST_DWAIT: begin
        if (div_rsp.done) begin
          state_d = cht_pkg::ST_FINISH;
        end
      end
      cht_pkg::ST_FINISH: begin
        if (out_free) begin
          state_d = cht_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = cht_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (finish) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cht_pkg::ST_CLEAR;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      value_q <= value_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;

  // The list marker carries no meaning for the table; it is only tied to an unused signal here.
  logic unused_last;
  assign unused_last = last_in_list_i;

  a_onehot_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("state register is not one-hot");

  a_accept_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == cht_pkg::ST_READ))
    else $error("accepted transfer did not start a table read");

  a_div_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == cht_pkg::ST_DWAIT))
    else $error("divider finished outside the wait state");

  a_write_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && (ram_wdata != '0)) |-> (state_q == cht_pkg::ST_FINISH))
    else $error("table entry written outside write-back");

  a_out_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == cht_pkg::ST_FINISH))
    else $error("result appeared without write-back");

endmodule

`default_nettype wire

// File: design/cht_ram.sv
// Generic single-port-write, single-port-read synchronous RAM with registered read data.
`default_nettype none

module cht_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// File: design/cht_divider.sv
// Serial restoring divider, two quotient bits per cycle, for the decay term.
`default_nettype none

module cht_divider (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire cht_pkg::div_req_t req_i,
  output cht_pkg::div_rsp_t      rsp_o
);

  logic                                   busy_q, busy_d;
  logic                                   done_q, done_d;
  logic [cht_pkg::DIV_CNT_W-1:0]          cnt_q, cnt_d;
  logic [cht_pkg::DIVISOR_W-1:0]          rem_q, rem_d;
  logic [cht_pkg::PROD_W-1:0]             quo_q, quo_d;
  logic [cht_pkg::DIVISOR_W-1:0]          den_q, den_d;
  logic [cht_pkg::DIVISOR_W-1:0]          rem_v;
  logic [cht_pkg::PROD_W-1:0]             quo_v;
  logic [cht_pkg::DIVISOR_W:0]            trial;

  always_comb begin
    rem_v = rem_q;
    quo_v = quo_q;
    trial = '0;
    for (int i = 0; i < cht_pkg::DIV_STEPS_PER_CYCLE; i++) begin
      trial = {rem_v, quo_v[cht_pkg::PROD_W-1]};
      if (trial >= {1'b0, den_q}) begin
        rem_v = cht_pkg::DIVISOR_W'(trial - {1'b0, den_q});
        quo_v = {quo_v[cht_pkg::PROD_W-2:0], 1'b1};
      end else begin
        rem_v = trial[cht_pkg::DIVISOR_W-1:0];
        quo_v = {quo_v[cht_pkg::PROD_W-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = req_i.dividend;
      den_d  = (req_i.divisor == '0) ? cht_pkg::DIVISOR_W'(1) : req_i.divisor;
    end else if (busy_q) begin
      rem_d = rem_v;
      quo_d = quo_v;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == cht_pkg::DIV_CNT_W'(cht_pkg::DIV_CYCLES - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

`default_nettype wire

// File: verif/capture_history_table_tb.sv
// Self-checking testbench for the capture history table: directed and random moves.
module capture_history_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cht_pkg::*;

  localparam int RANDOM_MOVES  = 1200;
  localparam int PHASE_MOVES   = 150;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 300;
  localparam int HOLD_AT       = 700;
  localparam int CALM_FROM     = 300;
  localparam int CALM_TO       = 500;

  localparam longint SCORE_MAX = 64'sd2147483647;
  localparam longint SCORE_MIN = -64'sd2147483648;

  typedef struct packed {
    logic       mode;
    logic [2:0] piece;
    logic [5:0] sq;
    logic [2:0] cap;
    logic       ep;
    logic       promo;
    logic       queen;
    logic       best;
    logic [6:0] depth;
    logic       last;
  } move_t;

  typedef struct {
    bit                          is_reg;
    cfg_idx_e                    reg_idx;
    logic [CFG_DAT_W-1:0]        reg_data;
    move_t                       mv;
    bit                          typed;
    logic signed [VALUE_W-1:0]   want;
  } step_t;

  logic                         clk_i               = 1'b0;
  logic                         rst_ni              = 1'b0;
  logic                         cfg_valid_i         = 1'b0;
  logic                         cfg_ready_o;
  logic [CFG_IDX_W-1:0]         cfg_index_i         = '0;
  logic [CFG_DAT_W-1:0]         cfg_data_i          = '0;
  logic                         in_valid_i          = 1'b0;
  logic                         in_stall_o;
  logic                         mode_i              = 1'b0;
  logic [2:0]                   mover_piece_i       = '0;
  logic [5:0]                   to_square_i         = '0;
  logic [2:0]                   captured_piece_i    = '0;
  logic                         is_en_passant_i     = 1'b0;
  logic                         is_promotion_i      = 1'b0;
  logic                         promotes_to_queen_i = 1'b0;
  logic                         is_best_i           = 1'b0;
  logic [DEPTH_W-1:0]           depth_i             = '0;
  logic                         last_in_list_i      = 1'b0;
  logic                         out_valid_o;
  logic                         out_stall_i         = 1'b0;
  logic signed [VALUE_W-1:0]    value_o;

  capture_history_table uut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .mode_i              (mode_i),
    .mover_piece_i       (mover_piece_i),
    .to_square_i         (to_square_i),
    .captured_piece_i    (captured_piece_i),
    .is_en_passant_i     (is_en_passant_i),
    .is_promotion_i      (is_promotion_i),
    .promotes_to_queen_i (promotes_to_queen_i),
    .is_best_i           (is_best_i),
    .depth_i             (depth_i),
    .last_in_list_i      (last_in_list_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .value_o             (value_o)
  );

  int                        scores [TABLE_DEPTH];
  logic [BONUS_W-1:0]        limit_reg = 16'd16384;
  logic [MULT_W-1:0]         mult_reg  = 8'd32;
  logic [DIVISOR_W-1:0]      div_reg   = 16'd512;
  logic signed [VALUE_W-1:0] pending_q [$];
  logic signed [VALUE_W-1:0] oldest;
  int                        errors       = 0;
  int                        results_seen = 0;
  int                        moves_sent   = 0;
  int                        hold_left    = 0;
  bit                        hold_done    = 1'b0;
  step_t                     dir_steps [$];

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    errors++;
  endtask

  function automatic logic signed [VALUE_W-1:0] apply_move(move_t m);
    logic [2:0] cap;
    int         slot;
    longint     e;
    longint     b;
    longint     d;
    longint     dv;
    longint     r;
    cap  = (m.ep || m.promo) ? 3'd0 : m.cap;
    slot = -1;
    if (m.piece < NUM_PIECE_TYPES && m.sq < NUM_SQUARES && cap < NUM_CAPTURED_TYPES) begin
      slot = (int'(m.piece) * NUM_SQUARES + int'(m.sq)) * NUM_CAPTURED_TYPES + int'(cap);
    end
    e = (slot >= 0) ? longint'(scores[slot]) : 64'sd0;
    if (m.mode == MODE_LOOKUP) begin
      r = e + (m.queen ? longint'(QUEEN_BONUS) : 64'sd0);
    end else begin
      b = longint'(m.depth) * longint'(m.depth);
      if (b > longint'(limit_reg)) b = longint'(limit_reg);
      d  = m.best ? b : -b;
      dv = (div_reg == '0) ? 64'sd1 : longint'(div_reg);
      r  = e + longint'(mult_reg) * d - (e * b) / dv;
      if (r > SCORE_MAX) r = SCORE_MAX;
      if (r < SCORE_MIN) r = SCORE_MIN;
      if (slot >= 0) scores[slot] = int'(r);
    end
    return VALUE_W'(r);
  endfunction

  function automatic move_t mv(logic mode, logic [2:0] piece, logic [5:0] sq, logic [2:0] cap,
                               logic ep, logic promo, logic queen, logic best,
                               logic [6:0] depth, logic last);
    return '{mode, piece, sq, cap, ep, promo, queen, best, depth, last};
  endfunction

  function automatic step_t item(move_t m, bit typed = 1'b0,
                                 logic signed [VALUE_W-1:0] want = '0);
    step_t s;
    s.is_reg   = 1'b0;
    s.reg_idx  = CFG_BONUS_LIMIT;
    s.reg_data = '0;
    s.mv       = m;
    s.typed    = typed;
    s.want     = want;
    return s;
  endfunction

  function automatic step_t reg_row(cfg_idx_e idx, logic [CFG_DAT_W-1:0] data);
    step_t s;
    s          = item('0);
    s.is_reg   = 1'b1;
    s.reg_idx  = idx;
    s.reg_data = data;
    return s;
  endfunction

  function automatic move_t rand_move(logic upd, logic best, logic [6:0] depth, logic last);
    move_t m;
    bit    hot;
    hot     = 1'($urandom_range(1));
    m.mode  = upd ? MODE_UPDATE : MODE_LOOKUP;
    if ($urandom_range(99) < 8) m.piece = 3'($urandom_range(7, 6));
    else m.piece = hot ? 3'($urandom_range(1)) : 3'($urandom_range(5));
    m.sq    = hot ? 6'($urandom_range(3)) : 6'($urandom);
    m.cap   = ($urandom_range(99) < 8) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
    m.ep    = ($urandom_range(99) < 10);
    m.promo = ($urandom_range(99) < 10);
    m.queen = 1'($urandom_range(1));
    m.best  = best;
    m.depth = depth;
    m.last  = last;
    return m;
  endfunction

  task automatic send_move(move_t m, bit typed = 1'b0, logic signed [VALUE_W-1:0] want = '0);
    logic signed [VALUE_W-1:0] got;
    while (!(moves_sent >= CALM_FROM && moves_sent < CALM_TO) && $urandom_range(99) < 8) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i          <= 1'b1;
    mode_i              <= m.mode;
    mover_piece_i       <= m.piece;
    to_square_i         <= m.sq;
    captured_piece_i    <= m.cap;
    is_en_passant_i     <= m.ep;
    is_promotion_i      <= m.promo;
    promotes_to_queen_i <= m.queen;
    is_best_i           <= m.best;
    depth_i             <= m.depth;
    last_in_list_i      <= m.last;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    got = apply_move(m);
    pending_q.push_back(typed ? want : got);
    moves_sent++;
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_DAT_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (cfg_ready_o !== 1'b1) @(posedge clk_i);
    case (idx)
      CFG_BONUS_LIMIT: limit_reg = data;
      CFG_BONUS_MULT:  mult_reg  = data[MULT_W-1:0];
      CFG_DECAY_DIV:   div_reg   = data;
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Result side: checks each transfer against the oldest prediction and drives the stall.
  always @(posedge clk_i) begin
    if (out_valid_o === 1'b1 && !out_stall_i) begin
      results_seen++;
      if (pending_q.size() == 0) begin
        report_mismatch($sformatf("value %0d arrived with no move pending", value_o));
      end else begin
        oldest = pending_q.pop_front();
        if (value_o !== oldest) begin
          report_mismatch($sformatf("result %0d: value %0d, expected %0d",
                                    results_seen, value_o, oldest));
        end
      end
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (!hold_done && results_seen >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_stall_i <= 1'b1;
    end else if (results_seen >= CALM_FROM && results_seen < CALM_TO) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(99) < 8);
    end
  end

  initial begin
    logic [CFG_DAT_W-1:0] lim;
    logic [CFG_DAT_W-1:0] mul;
    logic [CFG_DAT_W-1:0] dvs;
    logic [6:0]           depth;
    logic                 last;
    int                   len;
    int                   best_at;
    int                   looks;
    int                   phase_sent;

    // Reset, extremes, forced pawn captures, queen flag, out-of-range indexes.
    dir_steps.push_back(item(mv(MODE_LOOKUP, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, 33'sd0));
    dir_steps.push_back(item(mv(MODE_LOOKUP, 5, 63, 4, 0, 0, 1, 0, 0, 0), 1'b1, 33'sd64000));
    dir_steps.push_back(item(mv(MODE_UPDATE, 0, 0, 0, 0, 0, 0, 1, 0, 0)));
    dir_steps.push_back(item(mv(MODE_UPDATE, 5, 63, 4, 0, 0, 0, 1, 127, 1)));
    dir_steps.push_back(item(mv(MODE_UPDATE, 5, 63, 4, 0, 0, 0, 0, 127, 0)));
    dir_steps.push_back(item(mv(MODE_LOOKUP, 5, 63, 4, 0, 0, 1, 0, 0, 0)));
    dir_steps.push_back(item(mv(MODE_UPDATE, 2, 10, 3, 1, 0, 0, 1, 20, 0)));
    dir_steps.push_back(item(mv(MODE_LOOKUP, 2, 10, 0, 0, 0, 0, 0, 0, 0)));
    dir_steps.push_back(item(mv(MODE_UPDATE, 0, 56, 4, 0, 1, 1, 0, 9, 1)));
    dir_steps.push_back(item(mv(MODE_LOOKUP, 0, 56, 2, 0, 1, 0, 0, 0, 0)));
    dir_steps.push_back(item(mv(MODE_LOOKUP, 0, 56, 0, 0, 0, 1, 0, 0, 0)));
    dir_steps.push_back(item(mv(MODE_UPDATE, 6, 20, 1, 0, 0, 0, 1, 50, 0)));
    dir_steps.push_back(item(mv(MODE_UPDATE, 7, 5, 1, 0, 0, 0, 0, 127, 1)));
    dir_steps.push_back(item(mv(MODE_UPDATE, 1, 1, 7, 0, 0, 0, 1, 100, 0)));
    dir_steps.push_back(item(mv(MODE_LOOKUP, 7, 0, 5, 0, 0, 1, 0, 0, 0), 1'b1, 33'sd64000));
    dir_steps.push_back(reg_row(CFG_BONUS_LIMIT, 16'd0));
    dir_steps.push_back(item(mv(MODE_UPDATE, 5, 63, 4, 0, 0, 0, 1, 127, 0)));
    dir_steps.push_back(reg_row(CFG_BONUS_LIMIT, 16'hFFFF));
    dir_steps.push_back(reg_row(CFG_BONUS_MULT, 16'd0));
    dir_steps.push_back(reg_row(CFG_DECAY_DIV, 16'd0));
    dir_steps.push_back(item(mv(MODE_UPDATE, 5, 63, 4, 0, 0, 0, 1, 127, 0)));
    // Build a large entry, then drive it into both saturation limits with divisor one.
    dir_steps.push_back(reg_row(CFG_BONUS_MULT, 16'd255));
    dir_steps.push_back(reg_row(CFG_DECAY_DIV, 16'hFFFF));
    dir_steps.push_back(item(mv(MODE_UPDATE, 3, 30, 2, 0, 0, 0, 1, 127, 0), 1'b1, 33'sd4112895));
    dir_steps.push_back(reg_row(CFG_DECAY_DIV, 16'd1));
    dir_steps.push_back(item(mv(MODE_UPDATE, 3, 30, 2, 0, 0, 0, 0, 127, 0), 1'b1,
                             -33'sd2147483648));
    dir_steps.push_back(item(mv(MODE_LOOKUP, 3, 30, 2, 0, 0, 1, 0, 0, 0), 1'b1,
                             -33'sd2147419648));
    dir_steps.push_back(item(mv(MODE_UPDATE, 3, 30, 2, 0, 0, 0, 1, 127, 1), 1'b1,
                             33'sd2147483647));
    dir_steps.push_back(item(mv(MODE_LOOKUP, 3, 30, 2, 0, 0, 1, 0, 0, 0), 1'b1,
                             33'sd2147547647));

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_steps[i]) begin
      if (dir_steps[i].is_reg) begin
        drain();
        write_reg(dir_steps[i].reg_idx, dir_steps[i].reg_data);
      end else begin
        send_move(dir_steps[i].mv, dir_steps[i].typed, dir_steps[i].want);
      end
    end

    for (int ph = 0; ph < RANDOM_MOVES / PHASE_MOVES; ph++) begin
      drain();
      case ($urandom_range(3))
        0:       lim = 16'd0;
        1:       lim = 16'hFFFF;
        2:       lim = 16'($urandom_range(400));
        default: lim = 16'($urandom);
      endcase
      case ($urandom_range(2))
        0:       mul = 16'd0;
        1:       mul = 16'd255;
        default: mul = 16'($urandom_range(255));
      endcase
      case ($urandom_range(4))
        0:       dvs = 16'd0;
        1:       dvs = 16'd1;
        2:       dvs = 16'hFFFF;
        3:       dvs = 16'($urandom_range(1000, 1));
        default: dvs = 16'($urandom);
      endcase
      write_reg(CFG_BONUS_LIMIT, lim);
      write_reg(CFG_BONUS_MULT, mul);
      write_reg(CFG_DECAY_DIV, dvs);
      phase_sent = 0;
      while (phase_sent < PHASE_MOVES) begin
        len     = $urandom_range(8, 1);
        best_at = $urandom_range(len);
        depth   = 7'($urandom);
        for (int k = 0; k < len; k++) begin
          last = (k == len - 1);
          if ($urandom_range(99) < 10) last = ~last;
          send_move(rand_move(MODE_UPDATE, k == best_at, depth, last));
        end
        looks = $urandom_range(3);
        for (int k = 0; k < looks; k++) begin
          send_move(rand_move(MODE_LOOKUP, 1'($urandom_range(1)), 7'($urandom),
                              1'($urandom_range(1))));
        end
        phase_sent += len + looks;
      end
    end

    drain();
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// File: capture_history_table.f
design/cht_pkg.sv
design/cht_ram.sv
design/cht_divider.sv
design/capture_history_table.sv
verif/capture_history_table_tb.sv
